/* rtl/vbtsc_pkg.sv */
// Shared types, widths and helpers for the brake, traction and stability control unit.
// No dependencies; every other file imports this package.
package vbtsc_pkg;

  // Width of the signed speed fields.
  localparam int SPEED_WIDTH = 16;
  localparam int SLIP_W      = SPEED_WIDTH + 1;
  localparam int OVER_W      = SPEED_WIDTH + 1;
  localparam int YAW_W       = 16;
  localparam int AYAW_W      = YAW_W + 1;
  localparam int GAIN_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;

  // A per-lane brake step never needs more than this, since brakes never exceed 255.
  localparam int STEP_W      = 9;
  localparam logic [STEP_W-1:0] STEP_MAX = 9'd256;
  localparam int CALC_W      = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLIP_THRESHOLD = 3'd0,
    REG_SPIN_THRESHOLD = 3'd1,
    REG_YAW_THRESHOLD  = 3'd2,
    REG_SLIP_GAIN      = 3'd3,
    REG_SPIN_GAIN      = 3'd4,
    REG_YAW_GAIN       = 3'd5,
    REG_OUTPUT_LIMIT   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] slip_threshold;
    logic [BYTE_W-1:0] spin_threshold;
    logic [BYTE_W-1:0] yaw_threshold;
    logic [GAIN_W-1:0] slip_gain;
    logic [GAIN_W-1:0] spin_gain;
    logic [GAIN_W-1:0] yaw_gain;
    logic [BYTE_W-1:0] output_limit;
  } cfg_t;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // Stage-two control handed from the merge unit to the wheel lanes.
  typedef struct packed {
    logic              pass1;
    logic              pass2;
    logic [STEP_W-1:0] base_front;
    logic [STEP_W-1:0] base_rl;
    logic [STEP_W-1:0] base_rr;
  } lane_ctl_t;

  // Clamp a signed value into 0..lim.
  function automatic logic [BYTE_W-1:0] clamp_lim(input logic signed [CALC_W-1:0] x,
                                                   input logic [BYTE_W-1:0] lim);
    logic signed [CALC_W-1:0] lim_s;
    lim_s = signed'({{(CALC_W-BYTE_W){1'b0}}, lim});
    if (x < 0) begin
      return '0;
    end else if (x > lim_s) begin
      return lim;
    end else begin
      return x[BYTE_W-1:0];
    end
  endfunction

  // Smaller of a byte and the limit.
  function automatic logic [BYTE_W-1:0] min_lim(input logic [BYTE_W-1:0] x,
                                                 input logic [BYTE_W-1:0] lim);
    return (x > lim) ? lim : x;
  endfunction

endpackage

/* rtl/vbtsc_in_if.sv */
// Input channel of the control unit: one sensor sample per transaction.
// Depends on vbtsc_pkg.
interface vbtsc_in_if import vbtsc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] vehicle_speed;
  logic signed [SPEED_WIDTH-1:0] wheel_front_left;
  logic signed [SPEED_WIDTH-1:0] wheel_front_right;
  logic signed [SPEED_WIDTH-1:0] wheel_rear_left;
  logic signed [SPEED_WIDTH-1:0] wheel_rear_right;
  logic signed [YAW_W-1:0]       yaw_rate;
  logic [BYTE_W-1:0]             driver_brake;
  logic [BYTE_W-1:0]             driver_throttle;
  logic                          abs_enable;
  logic                          traction_enable;
  logic                          stability_enable;

  modport source (
    output valid, vehicle_speed, wheel_front_left, wheel_front_right, wheel_rear_left,
           wheel_rear_right, yaw_rate, driver_brake, driver_throttle, abs_enable,
           traction_enable, stability_enable,
    input  ready
  );
  modport sink (
    input  valid, vehicle_speed, wheel_front_left, wheel_front_right, wheel_rear_left,
           wheel_rear_right, yaw_rate, driver_brake, driver_throttle, abs_enable,
           traction_enable, stability_enable,
    output ready
  );
endinterface

/* rtl/vbtsc_out_if.sv */
// Result channel of the control unit: four brake commands and a throttle correction.
// Depends on vbtsc_pkg.
interface vbtsc_out_if import vbtsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] brake_front_left;
  logic [BYTE_W-1:0] brake_front_right;
  logic [BYTE_W-1:0] brake_rear_left;
  logic [BYTE_W-1:0] brake_rear_right;
  logic [BYTE_W-1:0] throttle_correction;

  modport source (
    output valid, brake_front_left, brake_front_right, brake_rear_left, brake_rear_right,
           throttle_correction,
    input  ready
  );
  modport sink (
    input  valid, brake_front_left, brake_front_right, brake_rear_left, brake_rear_right,
           throttle_correction,
    output ready
  );
endinterface

/* rtl/vbtsc_cfg_if.sv */
// Configuration write channel: register index and write data per transaction.
// Depends on vbtsc_pkg.
interface vbtsc_cfg_if import vbtsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/vbtsc_cfg.sv */
// Configuration register bank with reset values.
// Depends on vbtsc_pkg and vbtsc_cfg_if.
module vbtsc_cfg import vbtsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  vbtsc_cfg_if.sink   cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg      = cfg_r;

  // Register decode; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slip_threshold <= 8'd2;
      cfg_r.spin_threshold <= 8'd2;
      cfg_r.yaw_threshold  <= 8'd10;
      cfg_r.slip_gain      <= 7'd20;
      cfg_r.spin_gain      <= 7'd20;
      cfg_r.yaw_gain       <= 7'd15;
      cfg_r.output_limit   <= 8'd100;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SLIP_THRESHOLD: cfg_r.slip_threshold <= cfg_ch.data;
        REG_SPIN_THRESHOLD: cfg_r.spin_threshold <= cfg_ch.data;
        REG_YAW_THRESHOLD:  cfg_r.yaw_threshold  <= cfg_ch.data;
        REG_SLIP_GAIN:      cfg_r.slip_gain      <= cfg_ch.data[GAIN_W-1:0];
        REG_SPIN_GAIN:      cfg_r.spin_gain      <= cfg_ch.data[GAIN_W-1:0];
        REG_YAW_GAIN:       cfg_r.yaw_gain       <= cfg_ch.data[GAIN_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_r.output_limit   <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/vbtsc_lane.sv */
// One wheel lane: slip detection, anti-lock brake step and the brake command register.
// Depends on vbtsc_pkg.
module vbtsc_lane import vbtsc_pkg::*; (
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  cfg_t                          cfg,
  input  logic signed [SPEED_WIDTH-1:0] speed,
  input  logic signed [SPEED_WIDTH-1:0] wheel,
  input  logic                          pass1,
  input  logic                          pass2,
  input  logic [STEP_W-1:0]             base,
  output logic [BYTE_W-1:0]             brake
);

  localparam int PROD_W = SLIP_W + GAIN_W + 1;

  logic signed [SLIP_W-1:0] slip_nxt, slip_r;
  logic                     act_nxt, act_r;
  logic signed [PROD_W-1:0] prod;
  logic [STEP_W-1:0]        step_nxt, step_r;
  logic [BYTE_W-1:0]        b1_c, b2_c;
  logic [STEP_W-1:0]        b1, b2;
  logic [BYTE_W-1:0]        brake_nxt, brake_r;

  // Stage one: slip of this wheel below the vehicle speed.
  always_comb begin
    slip_nxt = SLIP_W'(speed) - SLIP_W'(wheel);
    act_nxt  = slip_nxt > signed'({{(SLIP_W-BYTE_W){1'b0}}, cfg.slip_threshold});
  end

  // Stage two: brake release step, saturated since brakes never exceed 255.
  always_comb begin
    prod = PROD_W'(slip_r) * signed'({{(PROD_W-GAIN_W){1'b0}}, cfg.slip_gain});
    if (!act_r) begin
      step_nxt = '0;
    end else if (prod > signed'(PROD_W'(STEP_MAX))) begin
      step_nxt = STEP_MAX;
    end else begin
      step_nxt = prod[STEP_W-1:0];
    end
  end

  // Stage three: up to two release passes, then the final clamp.
  always_comb begin
    b1_c = clamp_lim(signed'(CALC_W'(base)) - signed'(CALC_W'(step_r)), cfg.output_limit);
    b1   = pass1 ? STEP_W'(b1_c) : base;
    b2_c = clamp_lim(signed'(CALC_W'(b1)) - signed'(CALC_W'(step_r)), cfg.output_limit);
    b2   = pass2 ? STEP_W'(b2_c) : b1;
    brake_nxt = clamp_lim(signed'(CALC_W'(b2)), cfg.output_limit);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      slip_r <= slip_nxt;
      act_r  <= act_nxt;
    end
    if (en.s2) begin
      step_r <= step_nxt;
    end
    if (en.s3) begin
      brake_r <= brake_nxt;
    end
  end

  assign brake = brake_r;

endmodule

/* rtl/vbtsc_merge.sv */
// Yaw stability and traction path: builds lane base brakes, pass flags and the throttle
// correction. Depends on vbtsc_pkg.
module vbtsc_merge import vbtsc_pkg::*; (
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  cfg_t                          cfg,
  input  logic signed [SPEED_WIDTH-1:0] speed,
  input  logic signed [SPEED_WIDTH-1:0] wheel_rl,
  input  logic signed [SPEED_WIDTH-1:0] wheel_rr,
  input  logic signed [YAW_W-1:0]       yaw,
  input  logic [BYTE_W-1:0]             dbrake,
  input  logic [BYTE_W-1:0]             throttle,
  input  logic                          abs_en,
  input  logic                          trac_en,
  input  logic                          stab_en,
  output lane_ctl_t                     lane_ctl,
  output logic [BYTE_W-1:0]             corr
);

  localparam int SUM_W   = SPEED_WIDTH + 1;
  localparam int YPROD_W = AYAW_W + GAIN_W;
  localparam int TPROD_W = OVER_W + GAIN_W + 1;

  // Stage one signals.
  logic [AYAW_W-1:0]             ay;
  logic signed [SUM_W-1:0]       rsum;
  logic signed [SUM_W-1:0]       rsum_adj;
  logic signed [SPEED_WIDTH-1:0] avg;
  logic [AYAW_W-1:0]             ex_nxt, ex_r;
  logic                          yaw_act_nxt, yaw_act1_r;
  logic                          yaw_pos1_r, trac1_r, abs2_1_r;
  logic signed [OVER_W-1:0]      over_nxt, over_r;
  logic [BYTE_W-1:0]             dbrake1_r;

  // Stage two signals.
  logic [YPROD_W-1:0]            yprod;
  logic signed [TPROD_W-1:0]     tprod;
  logic                          over_act;
  logic [BYTE_W-1:0]             yc_nxt, yc_r;
  logic [BYTE_W-1:0]             tc_nxt, tc_r;
  logic                          yaw_act2_r, yaw_pos2_r, trac2_r, abs2_2_r;
  logic [BYTE_W-1:0]             dbrake2_r;

  // Stage three signals.
  logic [BYTE_W-1:0]             yc_lim;
  logic [BYTE_W-1:0]             bump;
  logic [BYTE_W-1:0]             corr_nxt, corr_r;

  // Stage one: excess yaw and rear-wheel overspeed.
  always_comb begin
    ay          = yaw[YAW_W-1] ? (AYAW_W'(0) - AYAW_W'(yaw)) : AYAW_W'(yaw);
    yaw_act_nxt = stab_en && (ay > AYAW_W'(cfg.yaw_threshold));
    ex_nxt      = ay - AYAW_W'(cfg.yaw_threshold);
    rsum        = SUM_W'(wheel_rl) + SUM_W'(wheel_rr);
    // Halve with truncation toward zero.
    rsum_adj    = rsum + SUM_W'(rsum[SUM_W-1]);
    avg         = rsum_adj[SUM_W-1:1];
    over_nxt    = OVER_W'(avg) - OVER_W'(speed);
  end

  // Stage two: gain products, saturated to a byte ahead of the limit clamp.
  always_comb begin
    yprod    = YPROD_W'(ex_r) * YPROD_W'(cfg.yaw_gain);
    yc_nxt   = (yprod > YPROD_W'(8'hFF)) ? 8'hFF : yprod[BYTE_W-1:0];
    over_act = over_r > signed'({{(OVER_W-BYTE_W){1'b0}}, cfg.spin_threshold});
    tprod    = TPROD_W'(over_r) * signed'({{(TPROD_W-GAIN_W){1'b0}}, cfg.spin_gain});
    if (!over_act) begin
      tc_nxt = '0;
    end else if (tprod > signed'(TPROD_W'(8'hFF))) begin
      tc_nxt = 8'hFF;
    end else begin
      tc_nxt = tprod[BYTE_W-1:0];
    end
  end

  // Stage three inputs: base brakes of each lane and the correction.
  always_comb begin
    yc_lim = min_lim(yc_r, cfg.output_limit);
    bump   = clamp_lim(signed'(CALC_W'(dbrake2_r)) + signed'(CALC_W'(yc_lim)),
                       cfg.output_limit);
    lane_ctl.pass1      = yaw_act2_r;
    lane_ctl.pass2      = abs2_2_r;
    lane_ctl.base_front = STEP_W'(dbrake2_r);
    lane_ctl.base_rl    = (yaw_act2_r && !yaw_pos2_r) ? STEP_W'(bump) : STEP_W'(dbrake2_r);
    lane_ctl.base_rr    = (yaw_act2_r && yaw_pos2_r) ? STEP_W'(bump) : STEP_W'(dbrake2_r);
    if (trac2_r) begin
      corr_nxt = min_lim(tc_r, cfg.output_limit);
    end else if (yaw_act2_r) begin
      corr_nxt = yc_lim;
    end else begin
      corr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ex_r       <= ex_nxt;
      yaw_act1_r <= yaw_act_nxt;
      yaw_pos1_r <= !yaw[YAW_W-1];
      over_r     <= over_nxt;
      trac1_r    <= trac_en && (throttle != '0);
      abs2_1_r   <= abs_en && (dbrake != '0);
      dbrake1_r  <= dbrake;
    end
    if (en.s2) begin
      yc_r       <= yc_nxt;
      tc_r       <= tc_nxt;
      yaw_act2_r <= yaw_act1_r;
      yaw_pos2_r <= yaw_pos1_r;
      trac2_r    <= trac1_r;
      abs2_2_r   <= abs2_1_r;
      dbrake2_r  <= dbrake1_r;
    end
    if (en.s3) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr = corr_r;

endmodule

/* rtl/vehicle_brake_traction_stability_control_unit.sv */
// Brake, traction and stability control unit: four wheel lanes plus a merge unit.
// A sample goes through the stage-one and stage-two registers to the stage-three output register.
// Throughput is one sample per cycle while out_ch.ready holds; the three-stage pipeline
// moves each stage on its own, so a waiting result does not stop earlier stages from filling.
// Synchronous active-low reset clears the stage valid bits and loads register defaults.
// Depends on vbtsc_pkg, the channel interfaces, vbtsc_cfg, vbtsc_lane and vbtsc_merge.
module vehicle_brake_traction_stability_control_unit import vbtsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  vbtsc_in_if.sink    in_ch,
  vbtsc_out_if.source out_ch,
  vbtsc_cfg_if.sink   cfg_ch
);

  cfg_t      cfg;
  pipe_en_t  en;
  lane_ctl_t lane_ctl;
  logic      v1_r, v2_r, v3_r;
  logic      free1, free2, free3;

  vbtsc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Each stage loads when it is empty or its contents move on.
  always_comb begin
    free3 = !v3_r || out_ch.ready;
    free2 = !v2_r || free3;
    free1 = !v1_r || free2;
    en.s1 = free1;
    en.s2 = free2;
    en.s3 = free3;
  end

  assign in_ch.ready  = free1;
  assign out_ch.valid = v3_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= in_ch.valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (free3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Wheel lanes.
  vbtsc_lane u_lane_fl (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .speed (in_ch.vehicle_speed),
    .wheel (in_ch.wheel_front_left),
    .pass1 (lane_ctl.pass1),
    .pass2 (lane_ctl.pass2),
    .base  (lane_ctl.base_front),
    .brake (out_ch.brake_front_left)
  );

  vbtsc_lane u_lane_fr (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .speed (in_ch.vehicle_speed),
    .wheel (in_ch.wheel_front_right),
    .pass1 (lane_ctl.pass1),
    .pass2 (lane_ctl.pass2),
    .base  (lane_ctl.base_front),
    .brake (out_ch.brake_front_right)
  );

  vbtsc_lane u_lane_rl (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .speed (in_ch.vehicle_speed),
    .wheel (in_ch.wheel_rear_left),
    .pass1 (lane_ctl.pass1),
    .pass2 (lane_ctl.pass2),
    .base  (lane_ctl.base_rl),
    .brake (out_ch.brake_rear_left)
  );

  vbtsc_lane u_lane_rr (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .speed (in_ch.vehicle_speed),
    .wheel (in_ch.wheel_rear_right),
    .pass1 (lane_ctl.pass1),
    .pass2 (lane_ctl.pass2),
    .base  (lane_ctl.base_rr),
    .brake (out_ch.brake_rear_right)
  );

  // Yaw and traction merge.
  vbtsc_merge u_merge (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .speed    (in_ch.vehicle_speed),
    .wheel_rl (in_ch.wheel_rear_left),
    .wheel_rr (in_ch.wheel_rear_right),
    .yaw      (in_ch.yaw_rate),
    .dbrake   (in_ch.driver_brake),
    .throttle (in_ch.driver_throttle),
    .abs_en   (in_ch.abs_enable),
    .trac_en  (in_ch.traction_enable),
    .stab_en  (in_ch.stability_enable),
    .lane_ctl (lane_ctl),
    .corr     (out_ch.throttle_correction)
  );

endmodule
